// ----- hw/rtl/sfa_pkg.sv -----
// sfa_pkg: shared types, constants and coefficient table for the structure
// factor accumulator. No dependencies.
package sfa_pkg;

  localparam int PHASE_BITS = 16;
  localparam int POS_W      = 24;
  localparam int K_W        = 32;
  localparam int ACC_W      = 36;
  localparam int S_W        = 52;
  localparam int DOT_W      = 74;
  localparam int MAG_W      = 72;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_K_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SET2 = 3'd4;

  localparam logic [31:0] C_A1 = 32'd1686629713;
  localparam logic [31:0] C_A3 = 32'd693598669;
  localparam logic [31:0] C_A5 = 32'd85569304;
  localparam logic [31:0] C_A7 = 32'd5026989;
  localparam logic [31:0] C_A9 = 32'd172272;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [15:0] SIN_MAX = 16'd32767;

  typedef logic [PHASE_BITS-1:0] phase_t;

  typedef struct packed {
    phase_t phase;
    logic   point_set;
    logic   last_point;
  } qent_t;

  typedef struct packed {
    logic [K_W-1:0] k_x;
    logic [K_W-1:0] k_y;
    logic [K_W-1:0] k_z;
  } kvec_t;

  typedef struct packed {
    logic [31:0] inv_count;
    logic        use_second_set;
  } bcfg_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_Z, B_P, B_S, B_ACC, B_M, B_ABS, B_INV, B_FIN
  } back_state_t;

  // horner coefficients after a9, in order of use
  function automatic logic [31:0] poly_coef(input logic [1:0] idx);
    logic [31:0] c;
    unique case (idx)
      2'd0: c = C_A7;
      2'd1: c = C_A5;
      2'd2: c = C_A3;
      default: c = C_A1;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/sfa_front.sv -----
// sfa_front: accepts particle items and forms the wrapped phase k.r with one
// shared multiplier. Depends on sfa_pkg.
module sfa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [sfa_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [sfa_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [sfa_pkg::POS_W-1:0] in_pos_z,
  input  logic                         in_point_set,
  input  logic                         in_last_point,
  input  sfa_pkg::kvec_t               kvec,
  input  logic                         q_full,
  output logic                         q_push,
  output sfa_pkg::qent_t               q_data
);

  sfa_pkg::front_state_t state_r, state_nxt;
  logic [sfa_pkg::POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic set_r, last_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] op_k;
  logic [sfa_pkg::POS_W-1:0] op_p;
  logic [63:0] prod;
  logic accept;

  always_comb begin
    unique case (cnt_r)
      2'd0: begin
        op_k = kvec.k_x;
        op_p = pos_x_r;
      end
      2'd1: begin
        op_k = kvec.k_y;
        op_p = pos_y_r;
      end
      default: begin
        op_k = kvec.k_z;
        op_p = pos_z_r;
      end
    endcase
  end

  // only the low 32 bits of each product reach the phase
  assign prod = {32'd0, op_k} *
                {32'd0, {(32 - sfa_pkg::POS_W){op_p[sfa_pkg::POS_W-1]}}, op_p};

  assign accept = in_valid && in_ready;
  assign q_data.phase = sum_r[31 -: sfa_pkg::PHASE_BITS];
  assign q_data.point_set = set_r;
  assign q_data.last_point = last_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    in_ready  = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      sfa_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = sfa_pkg::F_MUL;
          cnt_nxt   = 2'd0;
          sum_nxt   = 32'd0;
        end
      end
      sfa_pkg::F_MUL: begin
        sum_nxt = sum_r + prod[31:0];
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = sfa_pkg::F_PUSH;
        end
      end
      sfa_pkg::F_PUSH: begin
        q_push = !q_full;
        if (!q_full) begin
          state_nxt = sfa_pkg::F_IDLE;
        end
      end
      default: state_nxt = sfa_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfa_pkg::F_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (accept) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      set_r   <= in_point_set;
      last_r  <= in_last_point;
    end
  end

  a_push_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> $past(state_r) == sfa_pkg::F_MUL || $past(state_r) == sfa_pkg::F_PUSH)
    else $error("push without a finished phase");

  a_mul_three: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sfa_pkg::F_MUL |-> cnt_r != 2'd3)
    else $error("phase step count out of range");

endmodule

// ----- hw/rtl/sfa_queue.sv -----
// sfa_queue: short fifo of phase items between front and back.
// Depends on sfa_pkg.
module sfa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfa_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output sfa_pkg::qent_t pop_data,
  output logic           empty
);

  sfa_pkg::qent_t mem [sfa_pkg::Q_DEPTH];
  logic [sfa_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [sfa_pkg::Q_AW:0]   count_r;

  assign full     = count_r == (sfa_pkg::Q_AW + 1)'(sfa_pkg::Q_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue over or underflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[sfa_pkg::Q_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/sfa_back.sv -----
// sfa_back: cos/sin sequencer, set sums and structure factor at frame end,
// all on one shared 32x32 multiplier. Depends on sfa_pkg.
module sfa_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sfa_pkg::bcfg_t               bcfg,
  input  logic                         q_empty,
  input  sfa_pkg::qent_t               q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [sfa_pkg::ACC_W-1:0] out_sum_cos,
  output logic signed [sfa_pkg::ACC_W-1:0] out_sum_sin,
  output logic signed [sfa_pkg::S_W-1:0]   out_s_value
);

  localparam int PB = sfa_pkg::PHASE_BITS;

  sfa_pkg::back_state_t state_r, state_nxt;
  logic [1:0]  quad_r;
  logic [29:0] u_r;
  logic        set_r, last_r;
  logic [30:0] w_r, z_r;
  logic [31:0] p_r;
  logic [1:0]  pidx_r;
  logic        half_r;
  logic [15:0] sq_r, cq_r;
  logic [sfa_pkg::ACC_W-1:0] acc_ca_r, acc_sa_r, acc_cb_r, acc_sb_r;
  logic [2:0]  mstep_r;
  logic [1:0]  istep_r;
  logic [sfa_pkg::DOT_W-1:0] dot_r;
  logic [sfa_pkg::MAG_W-1:0] mag_r;
  logic        neg_r;
  logic [63:0] pa_r, pb_r, pc_r;
  logic        out_valid_r;
  logic [sfa_pkg::ACC_W-1:0] out_cos_r, out_sin_r;
  logic [sfa_pkg::S_W-1:0]   out_s_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [34:0] rnd;
  logic [15:0] smag;
  logic signed [16:0] c_val, s_val;
  logic [sfa_pkg::ACC_W-1:0] x_sel, y_sel, mx, my;
  logic [17:0] hx, hy;
  logic [5:0]  shamt;
  logic [sfa_pkg::DOT_W-1:0] term;
  logic        term_neg;
  logic [63:0] lim, rsum, rfin;
  logic        sat;
  logic        load_out;

  // operands of the dot product terms: step bit 2 picks cos or sin sums,
  // bits 1 and 0 pick the high or low half of each magnitude
  always_comb begin
    x_sel = mstep_r[2] ? acc_sa_r : acc_ca_r;
    if (bcfg.use_second_set) begin
      y_sel = mstep_r[2] ? acc_sb_r : acc_cb_r;
    end else begin
      y_sel = x_sel;
    end
    mx = x_sel[sfa_pkg::ACC_W-1] ? -x_sel : x_sel;
    my = y_sel[sfa_pkg::ACC_W-1] ? -y_sel : y_sel;
    hx = mstep_r[1] ? mx[35:18] : mx[17:0];
    hy = mstep_r[0] ? my[35:18] : my[17:0];
    shamt = (mstep_r[1] ? 6'd18 : 6'd0) + (mstep_r[0] ? 6'd18 : 6'd0);
    term_neg = x_sel[sfa_pkg::ACC_W-1] ^ y_sel[sfa_pkg::ACC_W-1];
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      sfa_pkg::B_Z: begin
        mul_a = {1'b0, w_r};
        mul_b = {1'b0, w_r};
      end
      sfa_pkg::B_P: begin
        mul_a = {1'b0, z_r};
        mul_b = p_r;
      end
      sfa_pkg::B_S: begin
        mul_a = {1'b0, w_r};
        mul_b = p_r;
      end
      sfa_pkg::B_M: begin
        mul_a = {14'd0, hx};
        mul_b = {14'd0, hy};
      end
      sfa_pkg::B_INV: begin
        unique case (istep_r)
          2'd0: mul_a = mag_r[31:0];
          2'd1: mul_a = mag_r[63:32];
          default: mul_a = {24'd0, mag_r[71:64]};
        endcase
        mul_b = bcfg.inv_count;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};
  assign term = {38'd0, prod[35:0]} << shamt;

  // q.30 quarter sine rounded half up to q.15 and saturated
  always_comb begin
    rnd  = {1'b0, prod[63:30]} + 35'h4000;
    smag = (rnd[34:15] > {4'd0, sfa_pkg::SIN_MAX}) ? sfa_pkg::SIN_MAX : rnd[30:15];
  end

  always_comb begin
    unique case (quad_r)
      2'd0: begin
        c_val = $signed({1'b0, cq_r});
        s_val = $signed({1'b0, sq_r});
      end
      2'd1: begin
        c_val = -$signed({1'b0, sq_r});
        s_val = $signed({1'b0, cq_r});
      end
      2'd2: begin
        c_val = -$signed({1'b0, cq_r});
        s_val = -$signed({1'b0, sq_r});
      end
      default: begin
        c_val = $signed({1'b0, sq_r});
        s_val = -$signed({1'b0, cq_r});
      end
    endcase
  end

  // scale by inv_count, round ties away from zero, saturate
  always_comb begin
    lim  = neg_r ? (64'd1 << (sfa_pkg::S_W - 1)) : ((64'd1 << (sfa_pkg::S_W - 1)) - 64'd1);
    sat  = (pc_r >= (64'd1 << 20)) || (pb_r >= (64'd1 << sfa_pkg::S_W));
    rsum = (pc_r << 32) + pb_r + ((pa_r + (64'd1 << 31)) >> 32);
    rfin = (sat || rsum > lim) ? lim : rsum;
  end

  assign load_out = (state_r == sfa_pkg::B_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      sfa_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = sfa_pkg::B_Z;
        end
      end
      sfa_pkg::B_Z: state_nxt = sfa_pkg::B_P;
      sfa_pkg::B_P: begin
        if (pidx_r == 2'd3) state_nxt = sfa_pkg::B_S;
      end
      sfa_pkg::B_S: state_nxt = half_r ? sfa_pkg::B_ACC : sfa_pkg::B_Z;
      sfa_pkg::B_ACC: state_nxt = last_r ? sfa_pkg::B_M : sfa_pkg::B_IDLE;
      sfa_pkg::B_M: begin
        if (mstep_r == 3'd7) state_nxt = sfa_pkg::B_ABS;
      end
      sfa_pkg::B_ABS: state_nxt = sfa_pkg::B_INV;
      sfa_pkg::B_INV: begin
        if (istep_r == 2'd2) state_nxt = sfa_pkg::B_FIN;
      end
      sfa_pkg::B_FIN: begin
        if (load_out) state_nxt = sfa_pkg::B_IDLE;
      end
      default: state_nxt = sfa_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfa_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      acc_ca_r    <= '0;
      acc_sa_r    <= '0;
      acc_cb_r    <= '0;
      acc_sb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == sfa_pkg::B_ACC) begin
        if (set_r) begin
          acc_cb_r <= acc_cb_r + {{(sfa_pkg::ACC_W - 17){c_val[16]}}, c_val};
          acc_sb_r <= acc_sb_r + {{(sfa_pkg::ACC_W - 17){s_val[16]}}, s_val};
        end else begin
          acc_ca_r <= acc_ca_r + {{(sfa_pkg::ACC_W - 17){c_val[16]}}, c_val};
          acc_sa_r <= acc_sa_r + {{(sfa_pkg::ACC_W - 17){s_val[16]}}, s_val};
        end
      end else if (load_out) begin
        acc_ca_r <= '0;
        acc_sa_r <= '0;
        acc_cb_r <= '0;
        acc_sb_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      sfa_pkg::B_IDLE: begin
        quad_r <= q_data.phase[PB-1 -: 2];
        u_r    <= {q_data.phase[PB-3:0], {(32 - PB){1'b0}}};
        w_r    <= {1'b0, q_data.phase[PB-3:0], {(32 - PB){1'b0}}};
        set_r  <= q_data.point_set;
        last_r <= q_data.last_point;
        half_r <= 1'b0;
      end
      sfa_pkg::B_Z: begin
        z_r    <= prod[60:30];
        p_r    <= sfa_pkg::C_A9;
        pidx_r <= 2'd0;
      end
      sfa_pkg::B_P: begin
        p_r    <= sfa_pkg::poly_coef(pidx_r) - prod[61:30];
        pidx_r <= pidx_r + 2'd1;
      end
      sfa_pkg::B_S: begin
        if (half_r) begin
          cq_r <= smag;
        end else begin
          sq_r   <= smag;
          w_r    <= sfa_pkg::ONE_Q30 - {1'b0, u_r};
          half_r <= 1'b1;
        end
      end
      sfa_pkg::B_ACC: begin
        mstep_r <= 3'd0;
        dot_r   <= '0;
      end
      sfa_pkg::B_M: begin
        dot_r   <= term_neg ? (dot_r - term) : (dot_r + term);
        mstep_r <= mstep_r + 3'd1;
      end
      sfa_pkg::B_ABS: begin
        neg_r   <= dot_r[sfa_pkg::DOT_W-1];
        mag_r   <= dot_r[sfa_pkg::DOT_W-1] ? sfa_pkg::MAG_W'(-dot_r)
                                           : dot_r[sfa_pkg::MAG_W-1:0];
        istep_r <= 2'd0;
      end
      sfa_pkg::B_INV: begin
        unique case (istep_r)
          2'd0: pa_r <= prod;
          2'd1: pb_r <= prod;
          default: pc_r <= prod;
        endcase
        istep_r <= istep_r + 2'd1;
      end
      sfa_pkg::B_FIN: begin
        if (load_out) begin
          out_cos_r <= acc_ca_r;
          out_sin_r <= acc_sa_r;
          out_s_r   <= neg_r ? sfa_pkg::S_W'(64'd0 - rfin) : rfin[sfa_pkg::S_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_sum_cos = out_cos_r;
  assign out_sum_sin = out_sin_r;
  assign out_s_value = out_s_r;

  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> acc_ca_r == '0 && acc_sa_r == '0 && acc_cb_r == '0 && acc_sb_r == '0)
    else $error("sums not cleared after frame result");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sfa_pkg::B_FIN)
    else $error("result raised outside frame end");

endmodule

// ----- hw/rtl/structure_factor_accumulator_top.sv -----
// structure_factor_accumulator_top: config registers, phase front, item
// queue and accumulate back end. Depends on sfa_pkg, sfa_front, sfa_queue, sfa_back.
//
//  channel | signals                                              | dir
//  in      | in_valid/in_ready, in_pos_x/y/z, in_point_set, in_last_point | in
//  out     | out_valid/out_ready, out_sum_cos, out_sum_sin, out_s_value   | out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data             | in
//
// the front takes one item at a time: accept, three phase products, then push.
// the back's cos/sin sequencer on its shared multiplier sets the rate, and
// on a last point it goes on to form the structure factor before the next item.
// reset is synchronous, active low; sums clear, inv_count resets to all ones.
// a 4-entry queue and the output register let either side stall on its own.
module structure_factor_accumulator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [sfa_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [sfa_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [sfa_pkg::POS_W-1:0] in_pos_z,
  input  logic                         in_point_set,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [sfa_pkg::ACC_W-1:0] out_sum_cos,
  output logic signed [sfa_pkg::ACC_W-1:0] out_sum_sin,
  output logic signed [sfa_pkg::S_W-1:0]   out_s_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  sfa_pkg::kvec_t kvec_r;
  sfa_pkg::bcfg_t bcfg_r;
  sfa_pkg::qent_t q_wdata, q_rdata;
  logic q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kvec_r <= '0;
      bcfg_r.inv_count      <= 32'hFFFF_FFFF;
      bcfg_r.use_second_set <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfa_pkg::CFG_K_X:      kvec_r.k_x <= cfg_data;
        sfa_pkg::CFG_K_Y:      kvec_r.k_y <= cfg_data;
        sfa_pkg::CFG_K_Z:      kvec_r.k_z <= cfg_data;
        sfa_pkg::CFG_INV_CNT:  bcfg_r.inv_count <= cfg_data;
        sfa_pkg::CFG_USE_SET2: bcfg_r.use_second_set <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sfa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_point_set (in_point_set),
    .in_last_point(in_last_point),
    .kvec         (kvec_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  sfa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  sfa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bcfg       (bcfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sum_cos(out_sum_cos),
    .out_sum_sin(out_sum_sin),
    .out_s_value(out_s_value)
  );

endmodule

// ----- dv/sfa_checker.sv -----
// sfa_checker: watches the in, out and cfg channels of the structure factor
// accumulator, predicts each frame result and compares. Depends on sfa_pkg.
`timescale 1ns / 1ps
module sfa_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [sfa_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [sfa_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [sfa_pkg::POS_W-1:0]  in_pos_z,
  input  logic                              in_point_set,
  input  logic                              in_last_point,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [sfa_pkg::ACC_W-1:0]  out_sum_cos,
  input  logic signed [sfa_pkg::ACC_W-1:0]  out_sum_sin,
  input  logic signed [sfa_pkg::S_W-1:0]    out_s_value,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  output int                                fail_count,
  output int                                frames_pending
);

  typedef struct {
    logic signed [sfa_pkg::ACC_W-1:0] sum_cos;
    logic signed [sfa_pkg::ACC_W-1:0] sum_sin;
    logic signed [sfa_pkg::S_W-1:0]   s_value;
  } frame_result_t;

  frame_result_t frame_q[$];

  logic signed [sfa_pkg::K_W-1:0]   kx, ky, kz;
  logic [31:0]                      inv_cnt;
  logic                             use_set2;
  logic signed [sfa_pkg::ACC_W-1:0] cos_a, sin_a, cos_b, sin_b;

  assign frames_pending = frame_q.size();

  initial fail_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // sin(pi/2*u), u in Q0.30, rounded magnitude in Q1.15
  function automatic logic [15:0] quarter_wave(input logic [63:0] u);
    logic [63:0] z, p, s;
    z = (u * u) >> 30;
    p = 64'(sfa_pkg::C_A9);
    p = 64'(sfa_pkg::C_A7) - ((z * p) >> 30);
    p = 64'(sfa_pkg::C_A5) - ((z * p) >> 30);
    p = 64'(sfa_pkg::C_A3) - ((z * p) >> 30);
    p = 64'(sfa_pkg::C_A1) - ((z * p) >> 30);
    s = (u * p) >> 30;
    s = (s + 64'(1 << 14)) >> 15;
    if (s > 64'(sfa_pkg::SIN_MAX)) s = 64'(sfa_pkg::SIN_MAX);
    return s[15:0];
  endfunction

  function automatic logic signed [sfa_pkg::S_W-1:0] structure_value(
      input logic signed [sfa_pkg::ACC_W-1:0] ra, input logic signed [sfa_pkg::ACC_W-1:0] ia,
      input logic signed [sfa_pkg::ACC_W-1:0] rb, input logic signed [sfa_pkg::ACC_W-1:0] ib);
    logic signed [127:0] dot, a1, a2, b1, b2;
    logic [127:0]        mag, prod, r, lim;
    logic                neg;
    a1 = ra; a2 = ia; b1 = rb; b2 = ib;
    dot = a1 * b1 + a2 * b2;
    neg = dot < 0;
    mag = neg ? -dot : dot;
    prod = mag * {96'd0, inv_cnt};
    r = (prod + (128'd1 << 31)) >> 32;
    lim = neg ? (128'd1 << (sfa_pkg::S_W - 1)) : ((128'd1 << (sfa_pkg::S_W - 1)) - 1);
    if (r > lim) r = lim;
    if (neg) r = -r;
    return r[sfa_pkg::S_W-1:0];
  endfunction

  // adds one point; when it ends the frame, queues the frame result and clears the sums
  task automatic accumulate_point(input logic signed [sfa_pkg::POS_W-1:0] px,
                                  input logic signed [sfa_pkg::POS_W-1:0] py,
                                  input logic signed [sfa_pkg::POS_W-1:0] pz,
                                  input logic set_b, input logic last);
    logic signed [63:0]               k64x, k64y, k64z, p64x, p64y, p64z, dot;
    logic [sfa_pkg::PHASE_BITS-1:0]   phase;
    logic [63:0]                      u;
    logic signed [sfa_pkg::ACC_W-1:0] sq, cq, c, s;
    frame_result_t                    res;
    k64x = kx; k64y = ky; k64z = kz;
    p64x = px; p64y = py; p64z = pz;
    dot = k64x * p64x + k64y * p64y + k64z * p64z;
    phase = dot[31:32-sfa_pkg::PHASE_BITS];
    u = 64'(phase[sfa_pkg::PHASE_BITS-3:0]) << (32 - sfa_pkg::PHASE_BITS);
    sq = sfa_pkg::ACC_W'(quarter_wave(u));
    cq = sfa_pkg::ACC_W'(quarter_wave(64'(sfa_pkg::ONE_Q30) - u));
    case (phase[sfa_pkg::PHASE_BITS-1:sfa_pkg::PHASE_BITS-2])
      2'd0: begin c = cq;  s = sq;  end
      2'd1: begin c = -sq; s = cq;  end
      2'd2: begin c = -cq; s = -sq; end
      default: begin c = sq; s = -cq; end
    endcase
    if (set_b) begin
      cos_b += c; sin_b += s;
    end else begin
      cos_a += c; sin_a += s;
    end
    if (last) begin
      res.sum_cos = cos_a;
      res.sum_sin = sin_a;
      res.s_value = use_set2 ? structure_value(cos_a, sin_a, cos_b, sin_b)
                             : structure_value(cos_a, sin_a, cos_a, sin_a);
      frame_q.push_back(res);
      cos_a = '0; sin_a = '0; cos_b = '0; sin_b = '0;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      kx = '0; ky = '0; kz = '0;
      inv_cnt = '1;
      use_set2 = 1'b0;
      cos_a = '0; sin_a = '0; cos_b = '0; sin_b = '0;
      frame_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfa_pkg::CFG_K_X:      kx = cfg_data;
          sfa_pkg::CFG_K_Y:      ky = cfg_data;
          sfa_pkg::CFG_K_Z:      kz = cfg_data;
          sfa_pkg::CFG_INV_CNT:  inv_cnt = cfg_data;
          sfa_pkg::CFG_USE_SET2: use_set2 = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_s_value), 64'd0);
        end else begin
          want = frame_q.pop_front();
          if (out_sum_cos !== want.sum_cos)
            report_mismatch("sum_cos", 64'(out_sum_cos), 64'(want.sum_cos));
          if (out_sum_sin !== want.sum_sin)
            report_mismatch("sum_sin", 64'(out_sum_sin), 64'(want.sum_sin));
          if (out_s_value !== want.s_value)
            report_mismatch("s_value", 64'(out_s_value), 64'(want.s_value));
        end
      end
      if (in_valid && in_ready)
        accumulate_point(in_pos_x, in_pos_y, in_pos_z, in_point_set, in_last_point);
    end
  end

endmodule

// ----- dv/tb_structure_factor_accumulator_top.sv -----
// tb_structure_factor_accumulator_top: clock, reset, frame stimulus, config
// phases and verdict. Depends on sfa_pkg, sfa_checker and the block's RTL.
`timescale 1ns / 1ps
module tb_structure_factor_accumulator_top;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [sfa_pkg::POS_W-1:0]  in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic                              in_point_set = 1'b0, in_last_point = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [sfa_pkg::ACC_W-1:0]  out_sum_cos, out_sum_sin;
  logic signed [sfa_pkg::S_W-1:0]    out_s_value;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [sfa_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [31:0]                       cfg_data = '0;
  int                                fail_count, frames_pending;
  int                                idle_pct = 0, stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  structure_factor_accumulator_top DUT (.*);

  sfa_checker checker_i (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_point(input logic signed [sfa_pkg::POS_W-1:0] x,
                            input logic signed [sfa_pkg::POS_W-1:0] y,
                            input logic signed [sfa_pkg::POS_W-1:0] z,
                            input logic set_b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    in_point_set <= set_b; in_last_point <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [sfa_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // lets all frames drain and the pipeline empty before touching registers
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_wave(input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z, input logic [31:0] inv, input logic two);
    drain();
    write_reg(sfa_pkg::CFG_K_X, x);
    write_reg(sfa_pkg::CFG_K_Y, y);
    write_reg(sfa_pkg::CFG_K_Z, z);
    write_reg(sfa_pkg::CFG_INV_CNT, inv);
    write_reg(sfa_pkg::CFG_USE_SET2, {31'd0, two});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [sfa_pkg::POS_W-1:0] rand_pos();
    case ($urandom_range(3))
      0: return sfa_pkg::POS_W'($urandom);
      1: return sfa_pkg::POS_W'($signed($urandom_range(2047)) - 1024);
      2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: return sfa_pkg::POS_W'($signed($urandom_range(65535)) - 32768);
    endcase
  endfunction

  function automatic logic [31:0] rand_k();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(4095)) - 2048);
    endcase
  endfunction

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1 << 26);
      2: return $urandom_range(1) ? 32'hffffffff : 32'h0;
      default: return $urandom_range(1 << 20);
    endcase
  endfunction

  task automatic random_frames(input int item_total);
    int sent, len;
    sent = 0;
    while (sent < item_total) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
      for (int j = 0; j < len; j++)
        send_point(rand_pos(), rand_pos(), rand_pos(), 1'($urandom_range(1)), j == len - 1);
      sent += len;
    end
  endtask

  initial begin
    int modes_idle[4] = '{0, 79, 0, 37};
    int modes_stall[4] = '{0, 0, 79, 37};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset config: k = 0, so every point sits at phase zero
    send_point(24'h7fffff, 24'h800000, 24'h0, 1'b0, 1'b0);
    send_point(24'h0, 24'h0, 24'h0, 1'b1, 1'b0);
    send_point(24'h800000, 24'h7fffff, 24'h7fffff, 1'b0, 1'b1);
    send_point(24'h000001, 24'hffffff, 24'h0, 1'b0, 1'b1);
    // out-of-range indexes must be ignored
    drain();
    write_reg(3'd5, 32'hffffffff);
    write_reg(3'd6, 32'h12345678);
    write_reg(3'd7, 32'hdeadbeef);
    cfg_valid <= 1'b0;
    send_point(24'h000100, 24'h0, 24'h0, 1'b0, 1'b1);
    // largest k, zero inv_count, cross set
    set_wave(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0, 1'b1);
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0, 1'b0);
    send_point(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0);
    send_point(24'h000001, 24'h0, 24'h0, 1'b1, 1'b1);
    // most negative k, full scale, set a alone with query points ignored
    set_wave(32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff, 1'b0);
    send_point(24'h7fffff, 24'h800000, 24'h000001, 1'b0, 1'b0);
    send_point(24'h000040, 24'h0, 24'h0, 1'b1, 1'b0);
    send_point(24'h0, 24'h0, 24'h0, 1'b0, 1'b1);
    // quarter-turn steps: k = 1 turn/unit, x = 0.25 units
    set_wave(32'h01000000, 32'h0, 32'h0, 32'hffffffff, 1'b1);
    for (int q = 0; q < 4; q++)
      send_point(24'(q * 64), 24'h0, 24'h0, 1'(q[0]), 1'b0);
    send_point(24'h000020, 24'h0, 24'h0, 1'b0, 1'b1);
    // query set only, so set a sums stay zero
    send_point(24'h000010, 24'h0, 24'h0, 1'b1, 1'b1);
    for (int ph = 0; ph < 8; ph++) begin
      set_wave(rand_k(), rand_k(), rand_k(), rand_inv(), 1'($urandom_range(1)));
      idle_pct = modes_idle[ph % 4];
      stall_pct = modes_stall[ph % 4];
      random_frames(100);
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
